FILE: rtl/assert_macros.svh
// assertion macros shared by the meter rtl
// expects clk and arst_n in the scope where they are used
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked every clock outside reset
`define ASSERT_ALWAYS(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// implication checked in the cycle after the trigger
`define ASSERT_NEXT(label, trig, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (trig) |=> (cons)) \
		else $error(msg);

`endif

FILE: rtl/vumbg_pkg.sv
// types, widths and divisor tables for the vu meter bar graph
// no dependencies
package vumbg_pkg;

	localparam int SEGMENT_COUNT = 15;
	localparam int SAMPLE_BITS   = 10;
	localparam int FS_W          = 10;
	localparam int DIV_W         = 14;
	localparam int SEG_W         = 16;
	localparam int IN_TDATA_W    = 16;
	localparam int CFG_IDX_W     = 2;
	localparam int FS100_W       = FS_W + 7;
	localparam int PROD_W        = SAMPLE_BITS + DIV_W;

	localparam logic [FS_W-1:0] FULL_SCALE_RST = FS_W'(180);
	localparam logic [FS100_W-1:0] PERCENT = FS100_W'(100);

	localparam logic REQ_SAMPLE = 1'b0;
	localparam logic REQ_FRAME  = 1'b1;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_FULL_SCALE   = 2'd0,
		REG_SCALE_MODE   = 2'd1,
		REG_DISPLAY_MODE = 2'd2
	} reg_idx_t;

	typedef struct packed {
		logic [FS_W-1:0] full_scale;
		logic            scale_mode;
		logic            display_mode;
	} meter_cfg_t;

	typedef logic [DIV_W-1:0] div_tbl_t [SEGMENT_COUNT];

	// divisors in hundredths, entry 0 belongs to the top segment
	localparam div_tbl_t LOG_DIV = '{
		14'd100, 14'd140, 14'd159, 14'd179, 14'd200, 14'd224, 14'd250, 14'd282,
		14'd316, 14'd357, 14'd455, 14'd625, 14'd1000, 14'd2000, 14'd10000
	};
	localparam div_tbl_t LIN_DIV = '{
		14'd100, 14'd107, 14'd115, 14'd125, 14'd136, 14'd150, 14'd167, 14'd186,
		14'd212, 14'd250, 14'd294, 14'd365, 14'd500, 14'd704, 14'd1316
	};

endpackage

FILE: rtl/vu_meter_bar_graph_unit.sv
// stereo vu meter: window peak per channel, bar or point pattern with decay
// depends on vumbg_pkg, vumbg_pattern, assert_macros.svh
// a frame item passes the input register, then the result register; only frame items give a result
// throughput: one item per cycle unless a frame item waits on a held result; set by the input and result registers
// reset: config to full scale 180, log scale, bar mode; peaks and held patterns zero
module vu_meter_bar_graph_unit (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                s_axis_tvalid,
	output logic                                s_axis_tready,
	input  logic [vumbg_pkg::IN_TDATA_W-1:0]    s_axis_tdata,  // sample_value, zero pad
	input  logic [1:0]                          s_axis_tuser,  // req_type, channel
	output logic                                m_axis_tvalid,
	input  logic                                m_axis_tready,
	output logic [vumbg_pkg::SEG_W-1:0]         m_axis_tdata,  // segments
	output logic                                m_axis_tuser,  // out_channel
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [vumbg_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [vumbg_pkg::FS_W-1:0]          cfg_data
);
	import vumbg_pkg::*;

	`include "assert_macros.svh"

	meter_cfg_t cfg_q;

	logic                   valid_s1;
	logic                   req_s1;
	logic                   chan_s1;
	logic [SAMPLE_BITS-1:0] smp_s1;

	logic [SAMPLE_BITS-1:0] peak_q [2];
	logic [SEG_W-1:0]       held_q [2];

	logic             out_valid_q;
	logic             out_chan_q;
	logic [SEG_W-1:0] out_seg_q;

	logic                   out_free;
	logic                   fire_s1;
	logic                   in_take;
	logic [SAMPLE_BITS-1:0] peak_cur;
	logic [SEG_W-1:0]       held_cur;
	logic [SEG_W-1:0]       held_next;
	logic [SEG_W-1:0]       pattern;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.full_scale   <= FULL_SCALE_RST;
			cfg_q.scale_mode   <= 1'b0;
			cfg_q.display_mode <= 1'b0;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_FULL_SCALE:   cfg_q.full_scale   <= cfg_data;
				REG_SCALE_MODE:   cfg_q.scale_mode   <= cfg_data[0];
				REG_DISPLAY_MODE: cfg_q.display_mode <= cfg_data[0];
				default: ;
			endcase
		end
	end

	assign out_free      = ~out_valid_q | m_axis_tready;
	assign fire_s1       = valid_s1 & ((req_s1 == REQ_SAMPLE) | out_free);
	assign s_axis_tready = ~valid_s1 | fire_s1;
	assign in_take       = s_axis_tvalid & s_axis_tready;

	assign peak_cur = peak_q[chan_s1];
	assign held_cur = held_q[chan_s1];

	vumbg_pattern u_pattern (
		.peak    (peak_cur),
		.cfg     (cfg_q),
		.pattern (pattern)
	);

	always_comb begin
		if (pattern > held_cur) begin
			held_next = pattern;
		end else if (pattern < held_cur) begin
			held_next = held_cur >> 1;
		end else begin
			held_next = held_cur;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
			peak_q[0]   <= '0;
			peak_q[1]   <= '0;
			held_q[0]   <= '0;
			held_q[1]   <= '0;
		end else begin
			valid_s1 <= in_take | (valid_s1 & ~fire_s1);
			if (fire_s1) begin
				if (req_s1 == REQ_SAMPLE) begin
					if (smp_s1 > peak_cur) begin
						peak_q[chan_s1] <= smp_s1;
					end
				end else begin
					peak_q[chan_s1] <= '0;
					held_q[chan_s1] <= held_next;
				end
			end
			if (fire_s1 && req_s1 == REQ_FRAME) begin
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (in_take) begin
			req_s1  <= s_axis_tuser[0];
			chan_s1 <= s_axis_tuser[1];
			smp_s1  <= s_axis_tdata[SAMPLE_BITS-1:0];
		end
		if (fire_s1 && req_s1 == REQ_FRAME) begin
			out_chan_q <= chan_s1;
			out_seg_q  <= held_next;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_seg_q;
	assign m_axis_tuser  = out_chan_q;

	`ASSERT_NEXT(a_frame_gives_result, fire_s1 && req_s1 == REQ_FRAME, m_axis_tvalid, "frame item without result")
	`ASSERT_NEXT(a_frame_clears_peak, fire_s1 && req_s1 == REQ_FRAME, peak_q[$past(chan_s1)] == '0, "peak not cleared after frame")
	`ASSERT_NEXT(a_decay_bounded, fire_s1 && req_s1 == REQ_FRAME, held_q[$past(chan_s1)] >= ($past(held_cur) >> 1), "held pattern fell faster than one halving")
	`ASSERT_ALWAYS(a_no_drop, !(valid_s1 && !fire_s1 && s_axis_tready), "input taken while stage holds an item")

endmodule

FILE: rtl/vumbg_pattern.sv
// peak to segment pattern: threshold compares, bar or point encoding
// depends on vumbg_pkg
module vumbg_pattern (
	input  logic [vumbg_pkg::SAMPLE_BITS-1:0] peak,
	input  vumbg_pkg::meter_cfg_t             cfg,
	output logic [vumbg_pkg::SEG_W-1:0]       pattern
);
	import vumbg_pkg::*;

	logic [FS100_W-1:0]       fs100;
	logic [SEGMENT_COUNT-1:0] pass;
	logic [SEGMENT_COUNT-1:0] chain;
	logic [SEG_W-1:0]         bar;
	logic [SEG_W-1:0]         point;

	assign fs100 = FS100_W'(cfg.full_scale) * PERCENT;

	// peak > floor(fs*100/d) is the same as peak*d > fs*100
	always_comb begin
		logic [PROD_W-1:0] prod_log;
		logic [PROD_W-1:0] prod_lin;
		for (int i = 0; i < SEGMENT_COUNT; i++) begin
			prod_log = PROD_W'(peak) * PROD_W'(LOG_DIV[SEGMENT_COUNT-1-i]);
			prod_lin = PROD_W'(peak) * PROD_W'(LIN_DIV[SEGMENT_COUNT-1-i]);
			pass[i] = (cfg.scale_mode ? prod_lin : prod_log) > PROD_W'(fs100);
		end
	end

	always_comb begin
		chain[0] = pass[0];
		for (int i = 1; i < SEGMENT_COUNT; i++) begin
			chain[i] = chain[i-1] & pass[i];
		end
	end

	assign bar = SEG_W'(chain);

	always_comb begin
		point = '0;
		point[0] = ~chain[0];
		for (int i = 1; i < SEGMENT_COUNT; i++) begin
			point[i] = chain[i-1] & ~chain[i];
		end
		point[SEGMENT_COUNT] = chain[SEGMENT_COUNT-1];
	end

	assign pattern = cfg.display_mode ? point : bar;

endmodule

FILE: tb/tb_vu_meter_bar_graph_unit.sv
// self-checking testbench for vu_meter_bar_graph_unit: directed and random words, random idling
// predicts window peaks, segment patterns and held patterns per channel and checks every result
// depends on vumbg_pkg and the rtl of vu_meter_bar_graph_unit
module tb_vu_meter_bar_graph_unit;
	timeunit 1ns;
	timeprecision 1ps;
	import vumbg_pkg::*;

	localparam int CYCLE_LIMIT = 300000;
	localparam int PHASES = 8;
	localparam int RANDOM_PER_PHASE = 54;
	localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

	// divisors in hundredths, entry 0 belongs to the top segment
	localparam int LOG_HUNDREDTHS [15] = '{100, 140, 159, 179, 200, 224, 250, 282,
		316, 357, 455, 625, 1000, 2000, 10000};
	localparam int LIN_HUNDREDTHS [15] = '{100, 107, 115, 125, 136, 150, 167, 186,
		212, 250, 294, 365, 500, 704, 1316};

	typedef struct packed {
		logic            req;
		logic            ch;
		logic [FS_W-1:0] smp;
	} meter_word_t;

	typedef struct packed {
		logic             ch;
		logic [SEG_W-1:0] seg;
	} display_word_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  s_axis_tvalid = 1'b0;
	logic                  s_axis_tready;
	logic [IN_TDATA_W-1:0] s_axis_tdata = '0;
	logic [1:0]            s_axis_tuser = '0;
	logic                  m_axis_tvalid;
	logic                  m_axis_tready = 1'b0;
	logic [SEG_W-1:0]      m_axis_tdata;
	logic                  m_axis_tuser;
	logic                  cfg_valid = 1'b0;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [FS_W-1:0]       cfg_data = '0;

	meter_word_t   pending_words[$];
	display_word_t display_expect[$];
	meter_word_t   next_word;
	display_word_t got_word;

	logic [FS_W-1:0]  scale_fs = FULL_SCALE_RST;
	logic             linear_scale = 1'b0;
	logic             point_display = 1'b0;
	logic [FS_W-1:0]  peak_level [2] = '{'0, '0};
	logic [SEG_W-1:0] held_segments [2] = '{'0, '0};

	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	int error_count = 0;
	int cycle_count = 0;

	vu_meter_bar_graph_unit dut (
		.clk(clk), .arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic logic [SEG_W-1:0] level_pattern(input logic [FS_W-1:0] peak);
		logic [SEG_W-1:0] pat;
		int thr;
		bit passing;
		pat = point_display ? SEG_W'(1) : SEG_W'(0);
		passing = 1'b1;
		for (int i = 0; i < SEGMENT_COUNT; i++) begin
			thr = (int'(scale_fs) * 100) /
				(linear_scale ? LIN_HUNDREDTHS[14 - i] : LOG_HUNDREDTHS[14 - i]);
			if (passing && int'(peak) > thr) begin
				if (point_display)
					pat = pat << 1;
				else
					pat[i] = 1'b1;
			end else begin
				passing = 1'b0;
			end
		end
		return pat;
	endfunction

	function automatic void meter_update(input logic req, input logic ch,
			input logic [FS_W-1:0] smp);
		logic [SEG_W-1:0] pat;
		display_word_t    res;
		if (req == REQ_SAMPLE) begin
			if (smp > peak_level[ch])
				peak_level[ch] = smp;
		end else begin
			pat = level_pattern(peak_level[ch]);
			if (held_segments[ch] < pat)
				held_segments[ch] = pat;
			else if (held_segments[ch] > pat)
				held_segments[ch] = held_segments[ch] >> 1;
			peak_level[ch] = '0;
			res.ch = ch;
			res.seg = held_segments[ch];
			display_expect.push_back(res);
		end
	endfunction

	task automatic push_word(input logic req, input logic ch, input int smp);
		meter_word_t w;
		w.req = req;
		w.ch = ch;
		w.smp = FS_W'(smp);
		pending_words.push_back(w);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [FS_W-1:0] val);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			REG_FULL_SCALE: scale_fs = val;
			REG_SCALE_MODE: linear_scale = val[0];
			REG_DISPLAY_MODE: point_display = val[0];
			default: ;
		endcase
		cfg_valid <= 1'b0;
	endtask

	task automatic wait_idle();
		while (pending_words.size() != 0 || s_axis_tvalid || display_expect.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// sender
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
			s_axis_tdata <= '0;
			s_axis_tuser <= '0;
		end else if (!s_axis_tvalid || s_axis_tready) begin
			if (pending_words.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
				next_word = pending_words.pop_front();
				s_axis_tvalid <= 1'b1;
				s_axis_tdata <= IN_TDATA_W'(next_word.smp);
				s_axis_tuser <= {next_word.ch, next_word.req};
			end else begin
				s_axis_tvalid <= 1'b0;
			end
		end
	end

	// receiver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			m_axis_tready <= 1'b0;
		else
			m_axis_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
	end

	// monitor
	always @(posedge clk) begin
		if (arst_n) begin
			if (m_axis_tvalid && m_axis_tready) begin
				if (display_expect.size() == 0) begin
					$error("result with nothing expected: out_channel %0d segments %h",
						m_axis_tuser, m_axis_tdata);
					error_count++;
				end else begin
					got_word = display_expect.pop_front();
					if (m_axis_tuser !== got_word.ch) begin
						$error("out_channel expected %0d actual %0d", got_word.ch, m_axis_tuser);
						error_count++;
					end
					if (m_axis_tdata !== got_word.seg) begin
						$error("segments expected %h actual %h", got_word.seg, m_axis_tdata);
						error_count++;
					end
				end
			end
			if (s_axis_tvalid && s_axis_tready)
				meter_update(s_axis_tuser[0], s_axis_tuser[1], s_axis_tdata[FS_W-1:0]);
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("tb_vu_meter_bar_graph_unit: errors");
			$finish;
		end
	end

	initial begin
		int fs_tbl [PHASES];
		int cap;
		logic [FS_W-1:0] fs;
		fs_tbl = '{180, 0, 1023, 1, 0, 1023, 0, 0};
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		for (int p = 0; p < PHASES; p++) begin
			case (p % 4)
				0: begin send_idle_pct = 0; recv_stall_pct = 0; end
				1: begin send_idle_pct = 74; recv_stall_pct = 0; end
				2: begin send_idle_pct = 0; recv_stall_pct = 74; end
				default: begin send_idle_pct = 15; recv_stall_pct = 15; end
			endcase
			// first phase runs on the reset settings
			if (p != 0) begin
				fs = (p >= 4 && fs_tbl[p] == 0) ? FS_W'($urandom_range(1, 1023)) : FS_W'(fs_tbl[p]);
				write_reg(REG_FULL_SCALE, fs);
				write_reg(REG_SCALE_MODE, FS_W'((p >> 1) & 1));
				write_reg(REG_DISPLAY_MODE, FS_W'(p & 1));
			end
			if (p == 1)
				write_reg(REG_UNUSED, FS_W'($urandom_range(0, 1023)));
			if (p == 0) begin
				// idle channels, full bar, decay, equal threshold, lowest segment
				push_word(REQ_FRAME, 1'b0, 0);
				push_word(REQ_FRAME, 1'b1, 1023);
				push_word(REQ_SAMPLE, 1'b0, 1023);
				push_word(REQ_FRAME, 1'b0, 0);
				push_word(REQ_FRAME, 1'b0, 0);
				push_word(REQ_SAMPLE, 1'b1, 180);
				push_word(REQ_SAMPLE, 1'b1, 100);
				push_word(REQ_FRAME, 1'b1, 0);
				push_word(REQ_SAMPLE, 1'b1, 181);
				push_word(REQ_FRAME, 1'b1, 0);
				push_word(REQ_SAMPLE, 1'b1, 181);
				push_word(REQ_FRAME, 1'b1, 0);
				push_word(REQ_SAMPLE, 1'b0, 2);
				push_word(REQ_FRAME, 1'b0, 0);
				push_word(REQ_SAMPLE, 1'b0, 1);
				push_word(REQ_FRAME, 1'b0, 0);
			end
			if (p == 1) begin
				// zero full scale in point mode: top bit, then decay and a floor of one
				push_word(REQ_SAMPLE, 1'b1, 1);
				push_word(REQ_FRAME, 1'b1, 0);
				push_word(REQ_FRAME, 1'b1, 0);
				push_word(REQ_SAMPLE, 1'b0, 0);
				push_word(REQ_FRAME, 1'b0, 0);
				push_word(REQ_FRAME, 1'b0, 0);
			end
			cap = int'(scale_fs) + int'(scale_fs) / 8 + 2;
			if (cap > 1023)
				cap = 1023;
			for (int n = 0; n < RANDOM_PER_PHASE; n++) begin
				if ($urandom_range(0, 99) < 30) begin
					push_word(REQ_FRAME, 1'($urandom_range(0, 1)), $urandom_range(0, 1023));
				end else begin
					case ($urandom_range(0, 3))
						0: push_word(REQ_SAMPLE, 1'($urandom_range(0, 1)), $urandom_range(0, 1023));
						1, 2: push_word(REQ_SAMPLE, 1'($urandom_range(0, 1)), $urandom_range(0, cap));
						default: push_word(REQ_SAMPLE, 1'($urandom_range(0, 1)),
							$urandom_range(0, cap / 16 + 1));
					endcase
				end
			end
			wait_idle();
		end
		if (error_count == 0)
			$display("tb_vu_meter_bar_graph_unit: clean");
		else
			$display("tb_vu_meter_bar_graph_unit: errors");
		$finish;
	end

endmodule

FILE: files.f
+incdir+rtl
rtl/vumbg_pkg.sv
rtl/vumbg_pattern.sv
rtl/vu_meter_bar_graph_unit.sv
tb/tb_vu_meter_bar_graph_unit.sv
